[src/sorf_pkg.sv]
// package for the sensor outlier reject filter
// field widths, reset values, register indexes and the history entry type
// no dependencies
package sorf_pkg;

	localparam int TEMP_W  = 12;
	localparam int HUM_W   = 10;
	localparam int PM_W    = 10;
	localparam int CO2_W   = 14;

	localparam int TEMP_LIM_W = 11;
	localparam int HUM_LIM_W  = 10;
	localparam int PM_LIM_W   = 10;
	localparam int CO2_LIM_W  = 14;

	localparam int CFG_DATA_W  = 14;
	localparam int CFG_INDEX_W = 2;

	localparam int DEPTH_DEFAULT = 8;

	localparam logic [TEMP_LIM_W-1:0] TEMP_LIMIT_RST = TEMP_LIM_W'(200);
	localparam logic [HUM_LIM_W-1:0]  HUM_LIMIT_RST  = HUM_LIM_W'(300);
	localparam logic [PM_LIM_W-1:0]   PM_LIMIT_RST   = PM_LIM_W'(70);
	localparam logic [CO2_LIM_W-1:0]  CO2_LIMIT_RST  = CO2_LIM_W'(400);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TEMP_LIMIT = 2'd0,
		REG_HUM_LIMIT  = 2'd1,
		REG_PM_LIMIT   = 2'd2,
		REG_CO2_LIMIT  = 2'd3
	} sorf_reg_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic [HUM_W-1:0]         hum;
		logic [PM_W-1:0]          pm;
		logic [CO2_W-1:0]         co2;
	} sorf_entry_t;

	localparam int ENTRY_W = $bits(sorf_entry_t);

	localparam sorf_entry_t HIST_RST = '{
		temp: TEMP_W'(200),
		hum:  HUM_W'(500),
		pm:   PM_W'(5),
		co2:  CO2_W'(500)
	};

endpackage

[src/sorf_sample_if.sv]
// input channel of the sensor outlier reject filter
// depends on sorf_pkg
interface sorf_sample_if import sorf_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] temp_in;
	logic [HUM_W-1:0]         hum_in;
	logic [PM_W-1:0]          pm_in;
	logic [CO2_W-1:0]         co2_in;

	modport source (output valid, temp_in, hum_in, pm_in, co2_in, input ready);
	modport sink (input valid, temp_in, hum_in, pm_in, co2_in, output ready);
endinterface

[src/sorf_result_if.sv]
// result channel of the sensor outlier reject filter
// depends on sorf_pkg
interface sorf_result_if import sorf_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] temp_out;
	logic [HUM_W-1:0]         hum_out;
	logic [PM_W-1:0]          pm_out;
	logic [CO2_W-1:0]         co2_out;
	logic                     rejected;

	modport source (output valid, temp_out, hum_out, pm_out, co2_out, rejected, input ready);
	modport sink (input valid, temp_out, hum_out, pm_out, co2_out, rejected, output ready);
endinterface

[src/sorf_ram.sv]
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module sorf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[src/sensor_outlier_reject_filter_unit.sv]
// top level of the sensor outlier reject filter
// depends on sorf_pkg, sorf_sample_if, sorf_result_if and sorf_ram
//
// usage:
// samples enter on the sample channel and results leave on the result channel,
// both valid/ready; a transfer happens when valid and ready are high together.
// each sample is compared per channel with the oldest entry of a DEPTH deep
// history ring; a jump strictly above its limit rejects the sample and the
// oldest entry goes out instead with rejected set, else the sample replaces
// the oldest entry and goes out unchanged.
// the sample passes through the input register and then the result register;
// one sample is taken per cycle while the receiver keeps result ready high;
// the ring ram is read one entry ahead of the pointer so the oldest entry
// sits in a register when the sample arrives.
// limits are written through cfg_we/cfg_index/cfg_data while the block idles;
// the user must keep to this, the block itself does not enforce it.
// reset sets the limits to their defaults, empties the pipeline and marks
// every ring entry as holding its reset value; no clearing pass is needed.
// when the receiver stalls the result register holds and the input register
// keeps one more sample, then ready drops.
module sensor_outlier_reject_filter_unit import sorf_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	sorf_sample_if.sink            sample,
	sorf_result_if.source          result
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
	endfunction

	logic [TEMP_LIM_W-1:0] temp_limit_q;
	logic [HUM_LIM_W-1:0]  hum_limit_q;
	logic [PM_LIM_W-1:0]   pm_limit_q;
	logic [CO2_LIM_W-1:0]  co2_limit_q;

	logic        valid_s1;
	sorf_entry_t data_s1;
	logic        res_valid_q;
	sorf_entry_t res_data_q;
	logic        res_rej_q;

	logic [PTR_W-1:0] ptr_q;
	sorf_entry_t      head_q;
	logic [DEPTH-1:0] vld_q;
	logic             byp_q;
	sorf_entry_t      byp_data_q;
	logic             rdv_q;

	logic             advance;
	logic             fire;
	logic             rej;
	logic             upd;
	logic [PTR_W-1:0] ptr_d;
	logic [PTR_W-1:0] rd_addr;
	logic [ENTRY_W-1:0] ram_rd;
	sorf_entry_t      nxt_entry;

	logic signed [TEMP_W:0] temp_diff;
	logic [TEMP_W:0]        temp_abs;
	logic [HUM_W:0]         hum_diff;
	logic [HUM_W:0]         hum_abs;
	logic [PM_W:0]          pm_diff;
	logic [PM_W:0]          pm_abs;
	logic [CO2_W:0]         co2_diff;
	logic [CO2_W:0]         co2_abs;

	// limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_limit_q <= TEMP_LIMIT_RST;
			hum_limit_q  <= HUM_LIMIT_RST;
			pm_limit_q   <= PM_LIMIT_RST;
			co2_limit_q  <= CO2_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (sorf_reg_t'(cfg_index))
				REG_TEMP_LIMIT: temp_limit_q <= cfg_data[TEMP_LIM_W-1:0];
				REG_HUM_LIMIT:  hum_limit_q  <= cfg_data[HUM_LIM_W-1:0];
				REG_PM_LIMIT:   pm_limit_q   <= cfg_data[PM_LIM_W-1:0];
				REG_CO2_LIMIT:  co2_limit_q  <= cfg_data[CO2_LIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance      = !res_valid_q || result.ready;
	assign fire         = valid_s1 && advance;
	assign sample.ready = !valid_s1 || advance;

	// per channel distance to the oldest entry
	always_comb begin
		temp_diff = {data_s1.temp[TEMP_W-1], data_s1.temp} - {head_q.temp[TEMP_W-1], head_q.temp};
		temp_abs  = temp_diff[TEMP_W] ? (TEMP_W+1)'(-temp_diff) : temp_diff;
		hum_diff  = {1'b0, data_s1.hum} - {1'b0, head_q.hum};
		hum_abs   = hum_diff[HUM_W] ? (HUM_W+1)'(-hum_diff) : hum_diff;
		pm_diff   = {1'b0, data_s1.pm} - {1'b0, head_q.pm};
		pm_abs    = pm_diff[PM_W] ? (PM_W+1)'(-pm_diff) : pm_diff;
		co2_diff  = {1'b0, data_s1.co2} - {1'b0, head_q.co2};
		co2_abs   = co2_diff[CO2_W] ? (CO2_W+1)'(-co2_diff) : co2_diff;
		rej = (temp_abs > (TEMP_W+1)'(temp_limit_q))
			|| (hum_abs > (HUM_W+1)'(hum_limit_q))
			|| (pm_abs > (PM_W+1)'(pm_limit_q))
			|| (co2_abs > (CO2_W+1)'(co2_limit_q));
	end

	assign upd     = fire && !rej;
	assign ptr_d   = upd ? ptr_inc(ptr_q) : ptr_q;
	assign rd_addr = ptr_inc(ptr_d);

	// entry one past the pointer, with write forwarding and reset value
	always_comb begin
		if (byp_q) begin
			nxt_entry = byp_data_q;
		end else if (rdv_q) begin
			nxt_entry = sorf_entry_t'(ram_rd);
		end else begin
			nxt_entry = HIST_RST;
		end
	end

	sorf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_ring (
		.clk     (clk),
		.we      (upd),
		.wr_addr (ptr_q),
		.wr_data (ENTRY_W'(data_s1)),
		.rd_addr (rd_addr),
		.rd_data (ram_rd)
	);

	// ring pointer, head register and prefetch control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			head_q     <= HIST_RST;
			vld_q      <= '0;
			byp_q      <= 1'b0;
			byp_data_q <= HIST_RST;
			rdv_q      <= 1'b0;
		end else begin
			ptr_q      <= ptr_d;
			byp_q      <= upd && (rd_addr == ptr_q);
			byp_data_q <= data_s1;
			rdv_q      <= vld_q[rd_addr];
			if (upd) begin
				vld_q[ptr_q] <= 1'b1;
				head_q       <= (DEPTH == 1) ? data_s1 : nxt_entry;
			end
		end
	end

	// input register and result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (sample.valid && sample.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			data_s1.temp <= sample.temp_in;
			data_s1.hum  <= sample.hum_in;
			data_s1.pm   <= sample.pm_in;
			data_s1.co2  <= sample.co2_in;
		end
		if (fire) begin
			res_data_q <= rej ? head_q : data_s1;
			res_rej_q  <= rej;
		end
	end

	assign result.valid    = res_valid_q;
	assign result.temp_out = res_data_q.temp;
	assign result.hum_out  = res_data_q.hum;
	assign result.pm_out   = res_data_q.pm;
	assign result.co2_out  = res_data_q.co2;
	assign result.rejected = res_rej_q;

endmodule
